// ===== design/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_BITS  = 5;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = 23;

    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_ADD = 6'h20;

    localparam logic [ADDR_BITS-1:0] TEXT_BASE = 23'h40_0000;

    typedef struct packed {
        logic                 en;
        logic [REG_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] data;
    } wb_t;

endpackage

`default_nettype wire

// ===== design/mse_ram.sv =====
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== design/mse_exec.sv =====
`default_nettype none

module mse_exec
    import mse_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  wire logic [WORD_BITS-1:0]  instr,
    input  wire logic [WORD_BITS-1:0]  rs_val,
    input  wire logic [WORD_BITS-1:0]  rt_val,
    input  wire logic [INDEX_BITS-1:0] cur_index,
    output wb_t                        wb,
    output logic                       taken,
    output logic      [INDEX_BITS-1:0] next_index
);

    logic [5:0]           opc;
    logic [5:0]           fn;
    logic [REG_BITS-1:0]  rt;
    logic [REG_BITS-1:0]  rd;
    logic [4:0]           sh;
    logic [15:0]          imm;
    logic [WORD_BITS-1:0] imm_sext;
    logic [INDEX_BITS-1:0] seq_index;
    logic                 wr;
    logic [REG_BITS-1:0]  dst;
    logic [WORD_BITS-1:0] val;

    assign opc      = instr[31:26];
    assign rt       = instr[20:16];
    assign rd       = instr[15:11];
    assign sh       = instr[10:6];
    assign fn       = instr[5:0];
    assign imm      = instr[15:0];
    assign imm_sext = {{16{imm[15]}}, imm};
    assign seq_index = cur_index + INDEX_BITS'(1);

    always_comb
    begin
        wr         = 1'b0;
        dst        = '0;
        val        = '0;
        taken      = 1'b0;
        next_index = seq_index;
        unique case (opc) inside
            OPC_RTYPE:
            begin
                unique case (fn)
                    FN_ADD:
                    begin
                        wr  = 1'b1;
                        dst = rd;
                        val = rt_val + rs_val;
                    end
                    FN_SLL:
                    begin
                        wr  = 1'b1;
                        dst = rd;
                        val = rt_val << sh;
                    end
                    FN_SRL:
                    begin
                        wr  = 1'b1;
                        dst = rd;
                        val = rt_val >> sh;
                    end
                    default:
                    begin
                        wr = 1'b0;
                    end
                endcase
            end
            OPC_ADDI:
            begin
                wr  = 1'b1;
                dst = rt;
                val = rs_val + imm_sext;
            end
            OPC_ANDI:
            begin
                wr  = 1'b1;
                dst = rt;
                val = rs_val & {16'h0000, imm};
            end
            OPC_BEQ, OPC_BNE:
            begin
                taken = (opc == OPC_BEQ) ? (rs_val == rt_val) : (rs_val != rt_val);
                if (taken)
                begin
                    next_index = seq_index + imm[INDEX_BITS-1:0];
                end
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
    end

    // writes to register zero are dropped
    always_comb
    begin
        wb.en   = wr && (dst != '0);
        wb.addr = wb.en ? dst : '0;
        wb.data = wb.en ? val : '0;
    end

endmodule

`default_nettype wire

// ===== design/mips_subset_execute_top.sv =====
// an accepted instruction is held in the input register, its result in the result register
// throughput: one instruction per cycle unless the output stalls; dependent ones via bypass
// register file sits in a 2-read 1-write ram with registered read, forwarded on a hit
// reset: instruction index to zero, per-register valid bits cleared so every register
// reads zero until written; no clearing pass, items accepted right after reset
`default_nettype none

module mips_subset_execute_top
    import mse_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [WORD_BITS-1:0] instruction,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [ADDR_BITS-1:0] instr_address,
    output logic                      write_enable,
    output logic      [REG_BITS-1:0]  write_reg,
    output logic      [WORD_BITS-1:0] write_value,
    output logic                      branch_taken,
    output logic      [7:0]           next_index
);

    logic                  accept;
    logic                  advance;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [WORD_BITS-1:0]  s1_instr_reg;

    logic [REG_COUNT-1:0]  rf_valid_reg;
    logic [REG_COUNT-1:0]  rf_valid_next;
    logic                  vld_a_reg;
    logic                  vld_b_reg;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    logic [WORD_BITS-1:0]  fwd_data_reg;
    logic [WORD_BITS-1:0]  ram_a;
    logic [WORD_BITS-1:0]  ram_b;
    logic [WORD_BITS-1:0]  rs_val;
    logic [WORD_BITS-1:0]  rt_val;

    logic [INDEX_BITS-1:0] index_reg;
    logic [INDEX_BITS-1:0] index_next;

    wb_t                   wb;
    logic                  taken;
    logic [INDEX_BITS-1:0] exec_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ADDR_BITS-1:0]  addr_out_reg;
    logic                  we_out_reg;
    logic [REG_BITS-1:0]   wreg_out_reg;
    logic [WORD_BITS-1:0]  wval_out_reg;
    logic                  taken_out_reg;
    logic [7:0]            next_out_reg;

    logic [REG_BITS-1:0]   in_rs;
    logic [REG_BITS-1:0]   in_rt;

    assign in_rs    = instruction[25:21];
    assign in_rt    = instruction[20:16];

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    mse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (REG_COUNT)
    ) u_rf (
        .clk     (clk),
        .we      (advance && wb.en),
        .waddr   (wb.addr),
        .wdata   (wb.data),
        .re      (accept),
        .raddr_a (in_rs),
        .raddr_b (in_rt),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // forwarded write wins, then never-written registers read zero
    assign rs_val = fwd_a_reg ? fwd_data_reg : (vld_a_reg ? ram_a : '0);
    assign rt_val = fwd_b_reg ? fwd_data_reg : (vld_b_reg ? ram_b : '0);

    mse_exec #(
        .INDEX_BITS (INDEX_BITS)
    ) u_exec (
        .instr      (s1_instr_reg),
        .rs_val     (rs_val),
        .rt_val     (rt_val),
        .cur_index  (index_reg),
        .wb         (wb),
        .taken      (taken),
        .next_index (exec_next)
    );

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);
        index_next     = advance ? exec_next : index_reg;
        rf_valid_next  = rf_valid_reg;
        if (advance && wb.en)
        begin
            rf_valid_next[wb.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            index_reg     <= index_next;
            rf_valid_reg  <= rf_valid_next;
        end
    end

    // operand capture alongside the registered ram read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instruction;
            vld_a_reg    <= rf_valid_reg[in_rs];
            vld_b_reg    <= rf_valid_reg[in_rt];
            fwd_a_reg    <= advance && wb.en && (wb.addr == in_rs);
            fwd_b_reg    <= advance && wb.en && (wb.addr == in_rt);
            fwd_data_reg <= wb.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr_out_reg  <= ADDR_BITS'(TEXT_BASE + (ADDR_BITS'(index_reg) << 2));
            we_out_reg    <= wb.en;
            wreg_out_reg  <= wb.addr;
            wval_out_reg  <= wb.data;
            taken_out_reg <= taken;
            next_out_reg  <= 8'(exec_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign instr_address = addr_out_reg;
    assign write_enable  = we_out_reg;
    assign write_reg     = wreg_out_reg;
    assign write_value   = wval_out_reg;
    assign branch_taken  = taken_out_reg;
    assign next_index    = next_out_reg;

endmodule

`default_nettype wire
